// ===== hw/rtl/sira_pkg.sv =====
// ----------------------------------------------------------------------------
// sira_pkg
// Shared widths, character codes and the digit-to-ASCII mapping for the
// signed integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package sira_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int NDIG_W      = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int DIGIT_W     = 6;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = 6'd10;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d8;
    d8 = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DEC_LIMIT) begin
      digit_char = CHAR_ZERO + d8;
    end else begin
      digit_char = CHAR_A + d8 - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_LIMIT};
    end
  endfunction

endpackage

// ===== hw/rtl/sira_div.sv =====
// ----------------------------------------------------------------------------
// sira_div
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module sira_div import sira_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]     remainder
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [DIGIT_W:0]       rsh;
  logic [DIGIT_W:0]       rdiff;
  logic                   ge;

  // shift the next dividend bit into the partial remainder
  assign rsh   = {rem_r, q_r[VALUE_WIDTH-1]};
  assign ge    = rsh >= {1'b0, divisor};
  assign rdiff = rsh - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt    = {q_r[VALUE_WIDTH-2:0], ge};
      rem_nxt  = ge ? rdiff[DIGIT_W-1:0] : rsh[DIGIT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/signed_int_to_radix_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii_unit
// Converts a signed integer to ASCII digits in a programmable base.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | word
//  ---------+-----+----------------------------------+----------------------
//  in_      | in  | in_tvalid/in_tready/in_tdata     | value[31:0]
//  out_     | out | out_tvalid/out_tready/out_tdata  | ascii_char[7:0], tlast
//  cfg_     | in  | cfg_wen/cfg_wdata                | radix[5:0]
//
//  Each digit is one full division on the bit-serial divider, so an item
//  of D digits runs D divisions before its first character is sent.
//  Characters leave one per cycle from a registered output stage;
//  out_tready low holds that stage and the emit sequence. A new word is
//  taken only once the previous word's last character is in that stage.
//  rst_n clears control state and sets radix to 10.
// ----------------------------------------------------------------------------
module signed_int_to_radix_ascii_unit import sira_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [VALUE_WIDTH-1:0] in_tdata,   // [31:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [CHAR_W-1:0]      out_tdata,  // [7:0] ascii_char
  output logic                   out_tlast,
  input  logic                   cfg_wen,
  input  logic [RADIX_W-1:0]     cfg_wdata   // [5:0] radix
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     base;
  logic                   neg_r, neg_nxt;
  logic [NDIG_W-1:0]      nd_r, nd_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [DIGIT_W-1:0]     digits_r [VALUE_WIDTH];
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  // unsigned magnitude, so the most negative value converts too
  assign mag_in    = in_tdata[VALUE_WIDTH-1] ? (~in_tdata + 1'b1) : in_tdata;

  assign div_dividend = (state_r == ST_IDLE) ? mag_in : div_quot;

  sira_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    nd_nxt         = nd_r;
    idx_nxt        = idx_r;
    div_start      = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          neg_nxt   = in_tdata[VALUE_WIDTH-1];
          nd_nxt    = '0;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          nd_nxt = nd_r + 1'b1;
          if (div_quot == '0) begin
            idx_nxt   = nd_r[IDX_W-1:0];
            state_nxt = ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = digit_char(digits_r[idx_r]);
            out_last_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      radix_r      <= RADIX_RESET;
      out_tvalid_r <= 1'b0;
      neg_r        <= 1'b0;
      nd_r         <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      neg_r        <= neg_nxt;
      nd_r         <= nd_nxt;
      idx_r        <= idx_nxt;
      if (cfg_wen) begin
        radix_r <= cfg_wdata;
      end
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit stack, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done) begin
      digits_r[nd_r[IDX_W-1:0]] <= div_rem;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule
